FILE: src/hgtr_pkg.sv
// ----------------------------------------------------------------------------
// hgtr_pkg
// Shared types, constants and the bar glyph rule of the glyph tile renderer.
// ----------------------------------------------------------------------------
package hgtr_pkg;

  localparam int ORIENTATIONS     = 9;
  localparam int ORIENT_W         = 4;
  localparam int BIN_W            = 16;
  localparam int WEIGHT_W         = 18;
  localparam int ACC_W            = 21;
  localparam int COORD_W          = 3;
  localparam int TILE_DIM_DEF     = 8;
  localparam int IN_DATA_W        = 48;
  localparam int OUT_DATA_W       = 24;

  localparam logic [ORIENT_W-1:0] LAST_ORIENT = ORIENT_W'(ORIENTATIONS - 1);

  // q16 slope per orientation: tangent for row-running bars, cotangent otherwise
  localparam int BAR_SLOPE [ORIENTATIONS] = '{
    0, -23853, -54991, -37837, -11556, 11556, 37837, 54991, 23853
  };
  // bit o set when the bar of orientation o runs along the rows
  localparam logic [ORIENTATIONS-1:0] BAR_RUNS_ROWS = 9'b001111000;

  typedef enum logic [1:0] {
    ST_ACC  = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  typedef struct packed {
    logic                       add;
    logic                       clear;
    logic [ORIENT_W-1:0]        orient;
    logic signed [WEIGHT_W-1:0] weight;
  } lane_ctrl_t;

  // which orientations set pixel (row, col) of a gs x gs tile
  function automatic logic [ORIENTATIONS-1:0] glyph_hits(int row, int col, int gs);
    logic [ORIENTATIONS-1:0] hits;
    int d2;
    int num;
    int u;
    hits = '0;
    for (int o = 0; o < ORIENTATIONS; o++) begin
      for (int t = 0; t < 8; t++) begin
        if (t < gs) begin
          d2  = 2 * t - (gs - 1);
          num = BAR_SLOPE[o] * d2 + gs * 65536;
          if (num < 0) begin
            num = 0;
          end
          u = num >>> 17;
          if (u > gs - 1) begin
            u = gs - 1;
          end
          if (BAR_RUNS_ROWS[o]) begin
            if (col == t && row == u) hits[o] = 1'b1;
          end else begin
            if (row == t && col == u) hits[o] = 1'b1;
          end
        end
      end
    end
    return hits;
  endfunction

endpackage

FILE: src/hog_glyph_tile_render.sv
// ----------------------------------------------------------------------------
// hog_glyph_tile_render
// Renders one HOG cell as a TILE_DIM x TILE_DIM glyph tile.
// ----------------------------------------------------------------------------
// A cell is nine requests, orientations 0 to 8, taken one per cycle; each
// request's weight (sum of its three bins) is added in the same cycle by one
// lane per tile row into every pixel the orientation's bar covers. After the
// ninth request the block stops taking input and sends the TILE_DIM^2
// pixels row by row, one per cycle while the output is not stalled,
// through the output register, clamped to the cell's weight range (which
// starts at zero). The single output register serializes the tile. The
// next cell's first request is taken while the last pixel still waits.
// ----------------------------------------------------------------------------
module hog_glyph_tile_render #(
  parameter int TILE_DIM = hgtr_pkg::TILE_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hgtr_pkg::IN_DATA_W-1:0]     in_tdata,   // bin_signed_first, bin_signed_second, bin_unsigned
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hgtr_pkg::OUT_DATA_W-1:0]    out_tdata,  // pixel_value, pixel_row, pixel_col
  output logic                               out_tlast   // last_pixel
);

  localparam int POS_W = $clog2(TILE_DIM);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(TILE_DIM - 1);

  hgtr_pkg::state_t                      state_r, state_nxt;
  logic [hgtr_pkg::ORIENT_W-1:0]         orient_r, orient_nxt;
  logic [POS_W-1:0]                      row_r, row_nxt;
  logic [POS_W-1:0]                      col_r, col_nxt;
  logic                                  take;
  logic                                  room;
  logic                                  load;
  logic                                  pix_last;
  logic signed [hgtr_pkg::WEIGHT_W-1:0]  weight;
  hgtr_pkg::lane_ctrl_t                  lane_ctrl;
  logic signed [hgtr_pkg::ACC_W-1:0]     lane_rd [TILE_DIM];

  assign in_tready = (state_r == hgtr_pkg::ST_ACC);
  assign take      = in_tvalid && in_tready;
  assign weight    = hgtr_pkg::WEIGHT_W'($signed(in_tdata[15:0]))
                   + hgtr_pkg::WEIGHT_W'($signed(in_tdata[31:16]))
                   + hgtr_pkg::WEIGHT_W'($signed(in_tdata[47:32]));

  assign load     = (state_r == hgtr_pkg::ST_EMIT) && room;
  assign pix_last = (row_r == POS_LAST) && (col_r == POS_LAST);

  always_comb begin
    state_nxt  = state_r;
    orient_nxt = orient_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    case (state_r)
      hgtr_pkg::ST_ACC: begin
        if (take) begin
          if (orient_r == hgtr_pkg::LAST_ORIENT) begin
            orient_nxt = '0;
            state_nxt  = hgtr_pkg::ST_EMIT;
          end else begin
            orient_nxt = orient_r + 1'b1;
          end
        end
      end
      hgtr_pkg::ST_EMIT: begin
        if (load) begin
          if (col_r == POS_LAST) begin
            col_nxt = '0;
            if (row_r == POS_LAST) begin
              row_nxt   = '0;
              state_nxt = hgtr_pkg::ST_ACC;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = hgtr_pkg::ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hgtr_pkg::ST_ACC;
      orient_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      orient_r <= orient_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
    end
  end

  assign lane_ctrl.add    = take;
  assign lane_ctrl.clear  = load && pix_last;
  assign lane_ctrl.orient = orient_r;
  assign lane_ctrl.weight = weight;

  for (genvar r = 0; r < TILE_DIM; r++) begin : g_lane
    hgtr_lane #(
      .TILE_DIM (TILE_DIM),
      .ROW      (r)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (lane_ctrl),
      .rd_col  (col_r),
      .rd_data (lane_rd[r])
    );
  end

  hgtr_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (take),
    .weight     (weight),
    .clear      (lane_ctrl.clear),
    .load       (load),
    .pix_acc    (lane_rd[row_r]),
    .pix_row    (hgtr_pkg::COORD_W'(row_r)),
    .pix_col    (hgtr_pkg::COORD_W'(col_r)),
    .pix_last   (pix_last),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_orient_range: assert property (@(posedge clk) disable iff (!rst_n)
    orient_r <= hgtr_pkg::LAST_ORIENT)
    else $error("orientation count out of range");
  a_ninth_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (take && orient_r == hgtr_pkg::LAST_ORIENT) |=> (state_r == hgtr_pkg::ST_EMIT))
    else $error("tile emission did not follow the ninth request");
  a_tile_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (load && pix_last) |=> (state_r == hgtr_pkg::ST_ACC && row_r == 0 && col_r == 0
                            && orient_r == 0))
    else $error("tile did not wrap cleanly after the last pixel");
  a_emit_idle_orient: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hgtr_pkg::ST_EMIT) |-> (orient_r == 0))
    else $error("orientation count moved during emission");

endmodule

FILE: src/hgtr_lane.sv
// ----------------------------------------------------------------------------
// hgtr_lane
// One tile row: accumulates the weight into every pixel of the row that the
// current orientation's bar covers, and reads one column back for emission.
// ----------------------------------------------------------------------------
module hgtr_lane #(
  parameter int TILE_DIM = hgtr_pkg::TILE_DIM_DEF,
  parameter int ROW      = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hgtr_pkg::lane_ctrl_t                 ctrl,
  input  logic [$clog2(TILE_DIM)-1:0]          rd_col,
  output logic signed [hgtr_pkg::ACC_W-1:0]    rd_data
);

  logic signed [hgtr_pkg::ACC_W-1:0] acc_r [TILE_DIM];

  for (genvar c = 0; c < TILE_DIM; c++) begin : g_col
    localparam logic [hgtr_pkg::ORIENTATIONS-1:0] HITS =
      hgtr_pkg::glyph_hits(ROW, c, TILE_DIM);

    always_ff @(posedge clk) begin
      if (!rst_n || ctrl.clear) begin
        acc_r[c] <= '0;
      end else if (ctrl.add && HITS[ctrl.orient]) begin
        acc_r[c] <= acc_r[c] + hgtr_pkg::ACC_W'(ctrl.weight);
      end
    end
  end

  assign rd_data = acc_r[rd_col];

endmodule

FILE: src/hgtr_merge.sv
// ----------------------------------------------------------------------------
// hgtr_merge
// Tracks the cell's weight range, clamps the selected lane pixel to it and
// holds the outgoing pixel in the output register.
// ----------------------------------------------------------------------------
module hgtr_merge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   upd,
  input  logic signed [hgtr_pkg::WEIGHT_W-1:0]   weight,
  input  logic                                   clear,
  input  logic                                   load,
  input  logic signed [hgtr_pkg::ACC_W-1:0]      pix_acc,
  input  logic [hgtr_pkg::COORD_W-1:0]           pix_row,
  input  logic [hgtr_pkg::COORD_W-1:0]           pix_col,
  input  logic                                   pix_last,
  output logic                                   room,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [hgtr_pkg::OUT_DATA_W-1:0]        out_tdata,  // pixel_value, pixel_row, pixel_col
  output logic                                   out_tlast   // last_pixel
);

  logic signed [hgtr_pkg::WEIGHT_W-1:0] min_r, min_nxt;
  logic signed [hgtr_pkg::WEIGHT_W-1:0] max_r, max_nxt;
  logic                                 out_valid_r;
  logic [hgtr_pkg::OUT_DATA_W-1:0]      out_data_r;
  logic                                 out_last_r;
  logic signed [hgtr_pkg::ACC_W-1:0]    lo_ext, hi_ext, clamped;

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (clear) begin
      min_nxt = '0;
      max_nxt = '0;
    end else if (upd) begin
      if (weight < min_r) min_nxt = weight;
      if (weight > max_r) max_nxt = weight;
    end
  end

  always_comb begin
    lo_ext  = hgtr_pkg::ACC_W'(min_r);
    hi_ext  = hgtr_pkg::ACC_W'(max_r);
    clamped = pix_acc;
    if (clamped > hi_ext) clamped = hi_ext;
    if (clamped < lo_ext) clamped = lo_ext;
  end

  assign room = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {pix_col, pix_row, clamped[hgtr_pkg::WEIGHT_W-1:0]};
      out_last_r <= pix_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_min_nonpos: assert property (@(posedge clk) disable iff (!rst_n) min_r <= 0)
    else $error("minimum weight above zero");
  a_max_nonneg: assert property (@(posedge clk) disable iff (!rst_n) max_r >= 0)
    else $error("maximum weight below zero");
  a_clear_range: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (min_r == 0 && max_r == 0))
    else $error("weight range not cleared after tile");

endmodule
